[hdl/rfam_pkg.sv]
// Shared types and constants for the register file ALU machine.
// Holds the word structs, opcode and sequencer enums; no dependencies.
package rfam_pkg;

  localparam int DataW          = 32;
  localparam int RegIdxW        = 2;
  localparam int ModeW          = 4;
  localparam int NumRegsDefault = 4;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD = 4'd0,
    MODE_MOVE = 4'd1,
    MODE_ADD  = 4'd2,
    MODE_SUB  = 4'd3,
    MODE_MUL  = 4'd4,
    MODE_DIV  = 4'd5,
    MODE_MOD  = 4'd6,
    MODE_AND  = 4'd7,
    MODE_OR   = 4'd8,
    MODE_XOR  = 4'd9,
    MODE_OUT  = 4'd10
  } mode_e;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [RegIdxW-1:0] dest_reg;
    logic [RegIdxW-1:0] first_source;
    logic [RegIdxW-1:0] second_source;
    logic               three_operand;
    logic signed [DataW-1:0] immediate;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    divide_error;
  } out_word_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_RD_A,
    SEQ_RD_B,
    SEQ_EXEC,
    SEQ_MUL_WB,
    SEQ_DIV_WAIT,
    SEQ_RESP
  } seq_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX,
    DIV_DONE
  } div_state_e;

endpackage

[hdl/rfam_div.sv]
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
// Depends on rfam_pkg for the data width and the divider state enum.
module rfam_div import rfam_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quo_o,
  output logic [DataW-1:0] rem_o
);

  localparam int CntW = $clog2(DataW);
  localparam logic [CntW-1:0] CntLast = CntW'(DataW - 1);

  div_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] quo_q, rem_q, den_q;
  logic             neg_q_q, neg_r_q;

  logic [DataW-1:0] a_mag, b_mag;
  logic [DataW:0]   shifted, diff;
  logic             ge;

  assign a_mag = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign b_mag = divisor_i[DataW-1]  ? (~divisor_i + 1'b1)  : divisor_i;

  // Partial remainder stays below the divisor, so the shifted value fits.
  assign shifted = {rem_q, quo_q[DataW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = ~diff[DataW];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (start_i) state_d = DIV_RUN;
      DIV_RUN:  if (cnt_q == CntLast) state_d = DIV_FIX;
      DIV_FIX:  state_d = DIV_DONE;
      DIV_DONE: state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          quo_q   <= a_mag;
          rem_q   <= '0;
          den_q   <= b_mag;
          neg_q_q <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
          neg_r_q <= dividend_i[DataW-1];
        end
      end
      DIV_RUN: begin
        rem_q <= ge ? diff[DataW-1:0] : shifted[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], ge};
      end
      DIV_FIX: begin
        // Apply signs: quotient by operand signs, remainder by dividend sign.
        if (neg_q_q) quo_q <= ~quo_q + 1'b1;
        if (neg_r_q) rem_q <= ~rem_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign done_o = (state_q == DIV_DONE);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[hdl/register_file_alu_machine.sv]
// Top level of the register file ALU machine: sequencer, register file, ALU.
// Depends on rfam_pkg and the iterative divider rfam_div.
//
//  channel | handshake             | word
//  --------+-----------------------+-------------------------------
//  in      | in_valid_i/in_stall_o | in_word_i  (one instruction)
//  out     | out_valid_o/out_stall_i | out_word_o (value, divide_error)
//
// One instruction at a time. Load, move, add, sub and logic ops read their
// operands in RD_A and RD_B and write back in EXEC; mul writes back in MUL_WB,
// out answers from RESP, and div and mod wait in DIV_WAIT while the divider
// produces one quotient bit per cycle, then fixes signs. The register file is
// cleared by reset at once. The output register holds a result under
// out_stall_i while the next instruction is accepted; a second result waits
// in the sequencer until the output register frees up.
module register_file_alu_machine import rfam_pkg::*; #(
  parameter int NUM_REGS = NumRegsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  seq_state_e state_q, state_d;
  in_word_t   inst_q;
  logic [DataW-1:0] op_a_q, op_a_d, op_b_q, op_b_d;
  logic [DataW-1:0] res_q, res_d;
  logic             err_q, err_d;
  logic [DataW-1:0] rf_q [NUM_REGS];

  logic               wr_en;
  logic [RegIdxW-1:0] wr_idx;
  logic [DataW-1:0]   wr_data;
  logic [RegIdxW-1:0] rd_idx, addr_a, addr_b;
  logic [DataW-1:0]   rd_data;
  logic [DataW-1:0]   mul_lo;

  logic             out_valid_q;
  out_word_t        out_word_q;
  logic             out_free, out_load;

  logic             div_start, div_done;
  logic [DataW-1:0] div_quo, div_rem;

  mode_e mode;
  assign mode = mode_e'(inst_q.mode);

  // Operand addresses: out reads dest, move reads first source.
  always_comb begin
    if (mode == MODE_OUT) begin
      addr_a = inst_q.dest_reg;
    end else if (mode == MODE_MOVE || inst_q.three_operand) begin
      addr_a = inst_q.first_source;
    end else begin
      addr_a = inst_q.dest_reg;
    end
    addr_b = inst_q.three_operand ? inst_q.second_source : inst_q.first_source;
  end

  assign rd_idx  = (state_q == SEQ_RD_A) ? addr_a : addr_b;
  assign rd_data = (32'(rd_idx) < NUM_REGS) ? rf_q[IdxW'(rd_idx)] : '0;

  assign mul_lo = DataW'(op_a_q * op_b_q);

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == SEQ_RESP) && out_free;

  always_comb begin
    state_d   = state_q;
    op_a_d    = op_a_q;
    op_b_d    = op_b_q;
    res_d     = res_q;
    err_d     = err_q;
    wr_en     = 1'b0;
    wr_idx    = inst_q.dest_reg;
    wr_data   = '0;
    div_start = 1'b0;
    unique case (state_q)
      SEQ_IDLE: if (in_valid_i) state_d = SEQ_RD_A;
      SEQ_RD_A: begin
        op_a_d  = rd_data;
        state_d = SEQ_RD_B;
      end
      SEQ_RD_B: begin
        op_b_d  = rd_data;
        state_d = SEQ_EXEC;
      end
      SEQ_EXEC: begin
        state_d = SEQ_IDLE;
        unique case (mode)
          MODE_LOAD: begin
            wr_en   = 1'b1;
            wr_data = inst_q.immediate;
          end
          MODE_MOVE: begin
            wr_en   = 1'b1;
            wr_data = op_a_q;
          end
          MODE_ADD: begin
            wr_en   = 1'b1;
            wr_data = op_a_q + op_b_q;
          end
          MODE_SUB: begin
            wr_en   = 1'b1;
            wr_data = op_a_q - op_b_q;
          end
          MODE_AND: begin
            wr_en   = 1'b1;
            wr_data = op_a_q & op_b_q;
          end
          MODE_OR: begin
            wr_en   = 1'b1;
            wr_data = op_a_q | op_b_q;
          end
          MODE_XOR: begin
            wr_en   = 1'b1;
            wr_data = op_a_q ^ op_b_q;
          end
          MODE_MUL: begin
            res_d   = mul_lo;
            state_d = SEQ_MUL_WB;
          end
          MODE_DIV, MODE_MOD: begin
            if (op_b_q == '0) begin
              // Drop the write and report the error instead.
              res_d   = '0;
              err_d   = 1'b1;
              state_d = SEQ_RESP;
            end else begin
              div_start = 1'b1;
              state_d   = SEQ_DIV_WAIT;
            end
          end
          MODE_OUT: begin
            res_d   = op_a_q;
            err_d   = 1'b0;
            state_d = SEQ_RESP;
          end
          default: state_d = SEQ_IDLE;
        endcase
      end
      SEQ_MUL_WB: begin
        wr_en   = 1'b1;
        wr_data = res_q;
        state_d = SEQ_IDLE;
      end
      SEQ_DIV_WAIT: begin
        if (div_done) begin
          wr_en   = 1'b1;
          wr_data = (mode == MODE_DIV) ? div_quo : div_rem;
          state_d = SEQ_IDLE;
        end
      end
      SEQ_RESP: if (out_free) state_d = SEQ_IDLE;
      default:  state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SEQ_IDLE && in_valid_i) begin
      inst_q <= in_word_i;
    end
    op_a_q <= op_a_d;
    op_b_q <= op_b_d;
    res_q  <= res_d;
    err_q  <= err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_q[i] <= '0;
      end
    end else if (wr_en && (32'(wr_idx) < NUM_REGS)) begin
      rf_q[IdxW'(wr_idx)] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q.value        <= res_q;
      out_word_q.divide_error <= err_q;
    end
  end

  rfam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (op_a_q),
    .divisor_i  (op_b_q),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign in_stall_o  = (state_q != SEQ_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == SEQ_DIV_WAIT)
    else $error("divider finished outside of the divide wait");

  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.divide_error |-> out_word_o.value == '0)
    else $error("error word carries a nonzero value");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEQ_IDLE |-> !wr_en)
    else $error("register write while idle");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == SEQ_RD_A)
    else $error("accepted word did not start operand read");

endmodule
